[rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion sampled on the rising clock, also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/mbrot_pkg.sv]
// Shared types, constants and helpers for the escape-time pixel block.
// No dependencies; imported by every module of the block.
`default_nettype none

package mbrot_pkg;

   // Image size; indexes beyond it are clamped to the last column or row.
   localparam int COLUMN_COUNT = 1024;
   localparam int ROW_COUNT    = 1024;

   // Field widths.
   localparam int COL_W   = 10;
   localparam int ROW_W   = 10;
   localparam int COORD_W = 32;
   localparam int COUNT_W = 16;
   localparam int PROD_W  = 2 * COORD_W;
   localparam int SUM_W   = 38;

   // Escape threshold 4.0 in unsigned Q8.56.
   localparam logic [PROD_W-1:0] ESCAPE_NORM = 64'h0400_0000_0000_0000;

   // Largest count the result can show.
   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

   // Register indexes on the configuration port.
   localparam int REG_IDX_W = 3;
   localparam logic [REG_IDX_W-1:0] REG_X_LEFT    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_Y_TOP     = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_X_STEP    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_Y_STEP    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_MAX_ITERS = 3'd4;
   localparam int ADDR_W = REG_IDX_W + 2;

   localparam logic [COUNT_W-1:0] MAX_ITERS_RESET = 16'd4096;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [COORD_W-1:0] coord_type;

   // Configuration values seen by the datapath.
   typedef struct packed {
      coord_type          x_left;
      coord_type          y_top;
      coord_type          x_step;
      coord_type          y_step;
      logic [COUNT_W-1:0] max_iters;
   } cfg_type;

   // One point c of the complex plane.
   typedef struct packed {
      coord_type c_re;
      coord_type c_im;
   } point_type;

   // Queue status toward both sides.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Saturate a wide signed sum to the signed 32-bit range.
   function automatic coord_type sat32(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(signed'({1'b0, {(COORD_W-1){1'b1}}}));
      lo = SUM_W'(signed'({1'b1, {(COORD_W-1){1'b0}}}));
      if (v > hi) begin
         sat32 = {1'b0, {(COORD_W-1){1'b1}}};
      end else if (v < lo) begin
         sat32 = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         sat32 = v[COORD_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

[rtl/mbrot_queue.sv]
// Short queue of points between the front and the back of the block.
// Depends on mbrot_pkg for the point type and the queue depth.
`default_nettype none

module mbrot_queue
   import mbrot_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire point_type        push_data,
   input  wire logic             pop,
   output point_type             pop_data,
   output queue_status_type      status
);

   point_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   fill_ff, fill_in;
   logic                     do_push;
   logic                     do_pop;

   assign status.full  = (fill_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (fill_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage; no reset needed for payload.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[rtl/mbrot_front.sv]
// Front of the block: accepts pixel beats, clamps indexes and forms the point c.
// Depends on mbrot_pkg; feeds mbrot_queue.
`default_nettype none

module mbrot_front
   import mbrot_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cfg_type          cfg,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [COL_W-1:0] req_column,
   input  wire logic [ROW_W-1:0] req_row,
   output logic                  push,
   output point_type             push_data,
   input  wire queue_status_type q_status
);

   logic [COL_W-1:0]                col_clamp;
   logic [ROW_W-1:0]                row_clamp;
   logic signed [COORD_W+COL_W:0]   prod_re;
   logic signed [COORD_W+ROW_W:0]   prod_im;
   logic [COORD_W-1:0]              prod_re_ff, prod_re_in;
   logic [COORD_W-1:0]              prod_im_ff, prod_im_in;
   logic                            valid_ff, valid_in;
   logic                            accept;
   logic                            advance;

   // Clamp indexes that fall beyond the image.
   assign col_clamp = (32'(req_column) >= COLUMN_COUNT) ? COL_W'(COLUMN_COUNT - 1) : req_column;
   assign row_clamp = (32'(req_row) >= ROW_COUNT) ? ROW_W'(ROW_COUNT - 1) : req_row;

   // Offset products; only the low 32 bits matter since the sum wraps.
   assign prod_re = cfg.x_step * $signed({1'b0, col_clamp});
   assign prod_im = cfg.y_step * $signed({1'b0, row_clamp});

   // The product stage drains into the queue whenever the queue has room.
   assign advance   = valid_ff && !q_status.full;
   assign req_stall = valid_ff && q_status.full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in   = valid_ff;
      prod_re_in = prod_re_ff;
      prod_im_in = prod_im_ff;
      if (accept) begin
         valid_in   = 1'b1;
         prod_re_in = prod_re[COORD_W-1:0];
         prod_im_in = prod_im[COORD_W-1:0];
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_re_ff <= prod_re_in;
      prod_im_ff <= prod_im_in;
   end

   // Add the origin, wrapping to 32 bits.
   assign push           = advance;
   assign push_data.c_re = cfg.x_left + coord_type'(prod_re_ff);
   assign push_data.c_im = cfg.y_top + coord_type'(prod_im_ff);

endmodule

`default_nettype wire

[rtl/mbrot_back.sv]
// Back of the block: iterates z = z*z + c for one point and holds the result beat.
// Depends on mbrot_pkg; takes points from mbrot_queue.
`default_nettype none

module mbrot_back
   import mbrot_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [COUNT_W-1:0]  max_iters,
   input  wire queue_status_type    q_status,
   input  wire point_type           pop_data,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [COUNT_W-1:0]       rsp_iteration_count
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_EVAL = 2'd2;

   logic [1:0]                 state_ff, state_in;
   point_type                  c_ff, c_in;
   coord_type                  zr_ff, zr_in;
   coord_type                  zi_ff, zi_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic signed [PROD_W-1:0]   sq_r_ff, sq_r_in;
   logic signed [PROD_W-1:0]   sq_i_ff, sq_i_in;
   logic signed [PROD_W-1:0]   cross_ff, cross_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]         rsp_count_ff, rsp_count_in;

   logic [PROD_W-1:0]          norm;
   logic signed [PROD_W-1:0]   diff;
   logic signed [SUM_W-1:0]    new_re;
   logic signed [SUM_W-1:0]    new_im;
   logic                       limit_hit;
   logic                       escaped;
   logic                       out_free;
   logic [COUNT_W-1:0]         final_count;

   // Evaluation of the registered products; the shifts keep the sign.
   assign norm      = $unsigned(sq_r_ff) + $unsigned(sq_i_ff);
   assign diff      = sq_r_ff - sq_i_ff;
   assign new_re    = SUM_W'(signed'(diff[PROD_W-1:28])) + SUM_W'(c_ff.c_re);
   assign new_im    = SUM_W'(signed'(cross_ff[PROD_W-1:27])) + SUM_W'(c_ff.c_im);
   assign limit_hit = (count_ff >= max_iters);
   assign escaped   = (norm >= ESCAPE_NORM);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // The final count saturates at the top of the 16-bit range.
   assign final_count = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + 1'b1;

   assign pop = (state_ff == ST_IDLE) && !q_status.empty;

   // Iteration sequencer: a multiply state and an evaluate state per pass.
   always_comb begin
      state_in     = state_ff;
      c_in         = c_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      count_in     = count_ff;
      sq_r_in      = sq_r_ff;
      sq_i_in      = sq_i_ff;
      cross_in     = cross_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_count_in = rsp_count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               c_in     = pop_data;
               zr_in    = '0;
               zi_in    = '0;
               count_in = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            sq_r_in  = zr_ff * zr_ff;
            sq_i_in  = zi_ff * zi_ff;
            cross_in = zr_ff * zi_ff;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (limit_hit || escaped) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = final_count;
                  state_in     = ST_IDLE;
               end
            end else begin
               zr_in    = sat32(new_re);
               zi_in    = sat32(new_im);
               count_in = count_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      c_ff         <= c_in;
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      count_ff     <= count_in;
      sq_r_ff      <= sq_r_in;
      sq_i_ff      <= sq_i_in;
      cross_ff     <= cross_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_iteration_count = rsp_count_ff;

endmodule

`default_nettype wire

[rtl/mandelbrot_escape_time_pixel.sv]
// Top level of the escape-time pixel block: register port, front, queue and back.
// Depends on mbrot_pkg, mbrot_front, mbrot_queue and mbrot_back.
//
// For each pixel beat (column, row) the block returns one beat with the
// escape-time count of c = (x_left + column*x_step, y_top + row*y_step),
// iterating z = z*z + c in signed Q4.28. Each point is loaded in the idle
// state; each pass then uses the three shared 32x32 multipliers in the
// multiply state and tests |z|^2 and updates z in the evaluate state. The
// default limit is 4096. The front registers its offset products, adds the
// origin as it pushes c, and keeps up to three pixels waiting (one in its
// product stage, two in the queue), and a finished result sits in an output
// register so the next pixel starts while it waits. The user must write registers
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module mandelbrot_escape_time_pixel
   import mbrot_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // Pixel channel.
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [COL_W-1:0]    req_column,
   input  wire logic [ROW_W-1:0]    req_row,
   // Result channel.
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [COUNT_W-1:0]       rsp_iteration_count,
   // Register port.
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [ADDR_W-1:0]   paddr,
   input  wire logic [31:0]         pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   cfg_type                 cfg_ff, cfg_in;
   logic [REG_IDX_W-1:0]    reg_idx;
   logic                    wr_en;
   logic                    push;
   logic                    pop;
   point_type               push_data;
   point_type               pop_data;
   queue_status_type        q_status;

   assign pready  = 1'b1;
   assign reg_idx = paddr[ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite && pready;

   // Register writes; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_X_LEFT:    cfg_in.x_left    = pwdata;
            REG_Y_TOP:     cfg_in.y_top     = pwdata;
            REG_X_STEP:    cfg_in.x_step    = pwdata;
            REG_Y_STEP:    cfg_in.y_step    = pwdata;
            REG_MAX_ITERS: cfg_in.max_iters = pwdata[COUNT_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_left    <= '0;
         cfg_ff.y_top     <= '0;
         cfg_ff.x_step    <= '0;
         cfg_ff.y_step    <= '0;
         cfg_ff.max_iters <= MAX_ITERS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register reads.
   always_comb begin
      unique case (reg_idx)
         REG_X_LEFT:    prdata = cfg_ff.x_left;
         REG_Y_TOP:     prdata = cfg_ff.y_top;
         REG_X_STEP:    prdata = cfg_ff.x_step;
         REG_Y_STEP:    prdata = cfg_ff.y_step;
         REG_MAX_ITERS: prdata = 32'(cfg_ff.max_iters);
         default:       prdata = '0;
      endcase
   end

   mbrot_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_column (req_column),
      .req_row    (req_row),
      .push       (push),
      .push_data  (push_data),
      .q_status   (q_status)
   );

   mbrot_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   mbrot_back u_back (
      .clock               (clock),
      .reset               (reset),
      .max_iters           (cfg_ff.max_iters),
      .q_status            (q_status),
      .pop_data            (pop_data),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_iteration_count (rsp_iteration_count)
   );

endmodule

`default_nettype wire

[rtl/mbrot_checker.sv]
// Port-level checks for the escape-time pixel block, bound to the top level.
// Depends on mbrot_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module mbrot_checker
   import mbrot_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [COUNT_W-1:0]  rsp_iteration_count,
   input wire logic                pready
);

   logic [3:0] pending_ff, pending_in;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat = req_valid && !req_stall;
   assign rsp_beat = rsp_valid && !rsp_stall;

   // Pixels accepted whose result beat has not yet gone out.
   always_comb begin
      pending_in = pending_ff;
      if (req_beat && !rsp_beat) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_beat && !req_beat) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A result beat is only shown for a pixel that was taken in.
   `ASSERT_CLK(a_no_extra_result, clock, reset, rsp_valid |-> pending_ff != 4'd0, "result without a pending pixel")
   // With nothing in flight the block must take a pixel at once.
   `ASSERT_CLK(a_idle_no_stall, clock, reset, pending_ff == 4'd0 |-> !req_stall, "stall while idle")
   // A stalled result beat stays up.
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "result beat dropped")
   // A stalled result beat keeps its count.
   `ASSERT_CLK(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_iteration_count), "result count changed while stalled")
   // The register port never inserts wait states.
   `ASSERT_ALWAYS(a_pready_high, clock, pready, "register port not ready")

endmodule

bind mandelbrot_escape_time_pixel mbrot_checker u_checker (.*);

`default_nettype wire

[dv/mandelbrot_escape_time_pixel_tb.sv]
// Self-checking testbench for the Mandelbrot escape-time pixel block.
// Depends on mbrot_pkg and mandelbrot_escape_time_pixel; drives pixels and register
// writes, and checks every result beat against a known count or an escape-time predictor.
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel_tb;
   import mbrot_pkg::*;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int DRAIN_CYCLES = 16;

   // Register index with no register behind it; writes there must be ignored.
   localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd5;

   typedef enum logic {PLAN_WRITE, PLAN_PIXEL} plan_kind_type;

   // One row of the directed table: a register write or a pixel beat.
   typedef struct packed {
      plan_kind_type          kind;
      logic [REG_IDX_W-1:0]   index;
      logic [31:0]            value;
      logic [COL_W-1:0]       column;
      logic [ROW_W-1:0]       row;
      logic                   known;
      logic [COUNT_W-1:0]     count;
   } plan_row_type;

   typedef enum {REGION_VIEW, REGION_ZOOM, REGION_WILD, REGION_DEEP} region_type;

   typedef struct {
      logic [COL_W-1:0]   column;
      logic [ROW_W-1:0]   row;
      logic [COUNT_W-1:0] count;
   } pixel_count_type;

   localparam int PLAN_LEN = 33;
   localparam plan_row_type PLAN [PLAN_LEN] = '{
      // Reset values: c = 0 never escapes, so the count is the limit plus one.
      '{PLAN_PIXEL, REG_X_LEFT,    32'h0000_0000,   10'd0,   10'd0, 1'b1, 16'd4097},
      '{PLAN_PIXEL, REG_X_LEFT,    32'h0000_0000, 10'd1023, 10'd1023, 1'b1, 16'd4097},
      // Zero limit.
      '{PLAN_WRITE, REG_MAX_ITERS, 32'h0000_0000,   10'd0,   10'd0, 1'b0, 16'd0},
      '{PLAN_PIXEL, REG_X_LEFT,    32'h0000_0000, 10'd512,   10'd3, 1'b1, 16'd1},
      '{PLAN_PIXEL, REG_X_LEFT,    32'h0000_0000, 10'd1023,  10'd0, 1'b1, 16'd1},
      // Limit of one.
      '{PLAN_WRITE, REG_MAX_ITERS, 32'h0000_0001,   10'd0,   10'd0, 1'b0, 16'd0},
      '{PLAN_PIXEL, REG_X_LEFT,    32'h0000_0000,   10'd0, 10'd1023, 1'b1, 16'd2},
      // c = 2.0 escapes on the second pass; upper bits of the limit write are dropped.
      '{PLAN_WRITE, REG_X_LEFT,    32'h2000_0000,   10'd0,   10'd0, 1'b0, 16'd0},
      '{PLAN_WRITE, REG_MAX_ITERS, 32'hABCD_0064,   10'd0,   10'd0, 1'b0, 16'd0},
      '{PLAN_PIXEL, REG_X_LEFT,    32'h0000_0000,   10'd0,   10'd0, 1'b1, 16'd2},
      // Classic view from (-2.0, -1.5) with a 3/1024 step.
      '{PLAN_WRITE, REG_X_LEFT,    32'hE000_0000,   10'd0,   10'd0, 1'b0, 16'd0},
      '{PLAN_WRITE, REG_X_STEP,    32'h000C_0000,   10'd0,   10'd0, 1'b0, 16'd0},
      '{PLAN_WRITE, REG_Y_TOP,     32'hE800_0000,   10'd0,   10'd0, 1'b0, 16'd0},
      '{PLAN_WRITE, REG_Y_STEP,    32'h000C_0000,   10'd0,   10'd0, 1'b0, 16'd0},
      '{PLAN_PIXEL, REG_X_LEFT,    32'h0000_0000,   10'd0,   10'd0, 1'b0, 16'd0},
      '{PLAN_PIXEL, REG_X_LEFT,    32'h0000_0000, 10'd1023, 10'd1023, 1'b0, 16'd0},
      '{PLAN_PIXEL, REG_X_LEFT,    32'h0000_0000, 10'd512, 10'd512, 1'b0, 16'd0},
      '{PLAN_PIXEL, REG_X_LEFT,    32'h0000_0000, 10'd700, 10'd300, 1'b0, 16'd0},
      '{PLAN_PIXEL, REG_X_LEFT,    32'h0000_0000, 10'd682, 10'd512, 1'b0, 16'd0},
      // Extreme origins and steps: the coordinate sums wrap to 32 bits.
      '{PLAN_WRITE, REG_X_LEFT,    32'h7FFF_FFFF,   10'd0,   10'd0, 1'b0, 16'd0},
      '{PLAN_WRITE, REG_X_STEP,    32'h7FFF_FFFF,   10'd0,   10'd0, 1'b0, 16'd0},
      '{PLAN_WRITE, REG_Y_TOP,     32'h8000_0000,   10'd0,   10'd0, 1'b0, 16'd0},
      '{PLAN_WRITE, REG_Y_STEP,    32'h8000_0000,   10'd0,   10'd0, 1'b0, 16'd0},
      '{PLAN_PIXEL, REG_X_LEFT,    32'h0000_0000,   10'd0,   10'd0, 1'b0, 16'd0},
      '{PLAN_PIXEL, REG_X_LEFT,    32'h0000_0000,   10'd1,   10'd1, 1'b0, 16'd0},
      '{PLAN_PIXEL, REG_X_LEFT,    32'h0000_0000, 10'd1023, 10'd1023, 1'b0, 16'd0},
      // Largest limit with c = 0: the count saturates at the top of the field.
      '{PLAN_WRITE, REG_X_LEFT,    32'h0000_0000,   10'd0,   10'd0, 1'b0, 16'd0},
      '{PLAN_WRITE, REG_X_STEP,    32'h0000_0000,   10'd0,   10'd0, 1'b0, 16'd0},
      '{PLAN_WRITE, REG_Y_TOP,     32'h0000_0000,   10'd0,   10'd0, 1'b0, 16'd0},
      '{PLAN_WRITE, REG_Y_STEP,    32'h0000_0000,   10'd0,   10'd0, 1'b0, 16'd0},
      '{PLAN_WRITE, REG_UNUSED,    32'h1234_5678,   10'd0,   10'd0, 1'b0, 16'd0},
      '{PLAN_WRITE, REG_MAX_ITERS, 32'h0000_FFFF,   10'd0,   10'd0, 1'b0, 16'd0},
      '{PLAN_PIXEL, REG_X_LEFT,    32'h0000_0000, 10'd300, 10'd700, 1'b1, 16'd65535}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [COL_W-1:0]     req_column = '0;
   logic [ROW_W-1:0]     req_row = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [COUNT_W-1:0]   rsp_iteration_count;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [ADDR_W-1:0]    paddr = '0;
   logic [31:0]          pwdata = '0;
   logic [31:0]          prdata;
   logic                 pready;

   // Register values as the block should hold them.
   cfg_type              plane;
   pixel_count_type      pending[$];
   int                   cycle_count = 0;
   int                   mismatches = 0;
   int                   pixels_sent = 0;
   int                   regs_written = 0;
   int                   results_checked = 0;
   int                   burst_left = 0;
   int                   stall_left = 0;
   int                   stall_mode = 0;

   mandelbrot_escape_time_pixel dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_column          (req_column),
      .req_row             (req_row),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_iteration_count (rsp_iteration_count),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always #6 clock = ~clock;

   // Clamp a wide intermediate to the signed Q4.28 range.
   function automatic longint clamp_q428(input longint v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // Escape-time count of one pixel under the current register values.
   function automatic logic [COUNT_W-1:0] escape_count(input logic [COL_W-1:0] col,
                                                       input logic [ROW_W-1:0] rw);
      logic [63:0]         re_sum;
      logic [63:0]         im_sum;
      coord_type           wrapped;
      longint              c_re;
      longint              c_im;
      longint              zr;
      longint              zi;
      longint              next_re;
      longint              next_im;
      longint unsigned     mag_re;
      longint unsigned     mag_im;
      longint unsigned     norm;
      int unsigned         passes;
      bit                  running;
      re_sum = longint'(plane.x_left) + longint'({1'b0, col}) * longint'(plane.x_step);
      im_sum = longint'(plane.y_top) + longint'({1'b0, rw}) * longint'(plane.y_step);
      wrapped = re_sum[31:0];
      c_re = wrapped;
      wrapped = im_sum[31:0];
      c_im = wrapped;
      zr = 0;
      zi = 0;
      passes = 0;
      running = 1'b1;
      while (running) begin
         if (passes >= plane.max_iters) begin
            passes++;
            running = 1'b0;
         end else begin
            passes++;
            mag_re = (zr < 0) ? -zr : zr;
            mag_im = (zi < 0) ? -zi : zi;
            norm = mag_re * mag_re + mag_im * mag_im;
            if (norm >= ESCAPE_NORM) begin
               running = 1'b0;
            end else begin
               // Floor shifts: arithmetic right shift of the exact products.
               next_re = ((zr * zr - zi * zi) >>> 28) + c_re;
               next_im = ((zr * zi) >>> 27) + c_im;
               zr = clamp_q428(next_re);
               zi = clamp_q428(next_im);
            end
         end
      end
      return (passes > 32'hFFFF) ? COUNT_MAX : passes[COUNT_W-1:0];
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatches < 40) begin
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      end
      mismatches++;
   endtask

   // Sender pacing: bursts of back-to-back beats separated by random gaps.
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            req_column <= COL_W'($urandom);
            req_row <= ROW_W'($urandom);
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   // Present one pixel beat, wait for it to be taken and record its count.
   task automatic push_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] rw,
                             input logic known, input logic [COUNT_W-1:0] count);
      pixel_count_type beat;
      bit              taken;
      pace_sender();
      @(negedge clock);
      req_valid <= 1'b1;
      req_column <= col;
      req_row <= rw;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !req_stall;
      end
      beat.column = col;
      beat.row = rw;
      beat.count = known ? count : escape_count(col, rw);
      pending.push_back(beat);
      pixels_sent++;
   endtask

   // Stop sending and wait until every pending result has come back.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write: setup phase, then access phase until pready.
   task automatic write_reg(input logic [REG_IDX_W-1:0] index, input logic [31:0] value);
      bit done;
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      done = 1'b0;
      while (!done) begin
         @(posedge clock);
         done = pready;
      end
      case (index)
         REG_X_LEFT:    plane.x_left = value;
         REG_Y_TOP:     plane.y_top = value;
         REG_X_STEP:    plane.x_step = value;
         REG_Y_STEP:    plane.y_step = value;
         REG_MAX_ITERS: plane.max_iters = value[COUNT_W-1:0];
         default: ;
      endcase
      regs_written++;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Reprogram every register for one region of the plane, then send random pixels.
   task automatic run_region(input region_type region, input int items);
      logic [31:0]        x0;
      logic [31:0]        y0;
      logic [31:0]        dx;
      logic [31:0]        dy;
      logic [31:0]        upper;
      logic [COUNT_W-1:0] limit;
      case (region)
         REGION_ZOOM: begin
            // Near the boundary around (-0.75, 0.1), with fine steps.
            x0 = 32'hF400_0000 + $urandom_range(0, 32'h0040_0000);
            y0 = $urandom_range(0, 32'h0200_0000);
            dx = $urandom_range(32'h100, 32'h4000);
            dy = $urandom_range(32'h100, 32'h4000);
            limit = COUNT_W'($urandom_range(0, 255));
         end
         REGION_WILD: begin
            x0 = $urandom;
            y0 = $urandom;
            dx = $urandom;
            dy = $urandom;
            limit = COUNT_W'($urandom_range(0, 255));
         end
         default: begin
            // Whole-set view; the deep variant raises the limit.
            x0 = 32'hE000_0000 + $urandom_range(0, 32'h0800_0000);
            y0 = 32'hE800_0000 + $urandom_range(0, 32'h0800_0000);
            dx = $urandom_range(32'h1_0000, 32'h8_0000);
            dy = $urandom_range(32'h1_0000, 32'h8_0000);
            limit = (region == REGION_DEEP) ? COUNT_W'($urandom_range(500, 1500))
                                            : COUNT_W'($urandom_range(0, 255));
         end
      endcase
      upper = $urandom;
      wait_idle();
      write_reg(REG_X_LEFT, x0);
      write_reg(REG_Y_TOP, y0);
      write_reg(REG_X_STEP, dx);
      write_reg(REG_Y_STEP, dy);
      write_reg(REG_MAX_ITERS, {upper[31:16], limit});
      for (int n = 0; n < items; n++) begin
         push_pixel(COL_W'($urandom_range(0, 1023)), ROW_W'($urandom_range(0, 1023)),
                    1'b0, '0);
      end
   endtask

   // Receiver: steady runs, short and long holds and coin-flip stretches of stall.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 4);
         case (stall_mode)
            0, 1: stall_left = $urandom_range(1, 60);
            2:    stall_left = $urandom_range(1, 6);
            3:    stall_left = $urandom_range(20, 80);
            default: stall_left = $urandom_range(10, 40);
         endcase
      end
      case (stall_mode)
         0, 1:    rsp_stall <= 1'b0;
         2, 3:    rsp_stall <= 1'b1;
         default: rsp_stall <= 1'($urandom_range(0, 1));
      endcase
      stall_left--;
   end

   // Result monitor: each accepted beat is matched with the oldest pending count.
   always @(posedge clock) begin : result_check
      pixel_count_type beat;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending.size() == 0) begin
            report_mismatch($sformatf("result %0d with no pixel pending",
                                      rsp_iteration_count));
         end else begin
            beat = pending.pop_front();
            results_checked++;
            if (rsp_iteration_count !== beat.count) begin
               report_mismatch($sformatf("pixel (%0d,%0d): count %0d, expected %0d",
                                         beat.column, beat.row,
                                         rsp_iteration_count, beat.count));
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("run stopped at the cycle limit with %0d results outstanding",
                  pending.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      plane.x_left = '0;
      plane.y_top = '0;
      plane.x_step = '0;
      plane.y_step = '0;
      plane.max_iters = MAX_ITERS_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table.
      for (int i = 0; i < PLAN_LEN; i++) begin
         if (PLAN[i].kind == PLAN_WRITE) begin
            wait_idle();
            write_reg(PLAN[i].index, PLAN[i].value);
         end else begin
            push_pixel(PLAN[i].column, PLAN[i].row, PLAN[i].known, PLAN[i].count);
         end
      end

      // Random regions of the plane.
      run_region(REGION_VIEW, 24);
      run_region(REGION_WILD, 20);
      run_region(REGION_ZOOM, 24);
      run_region(REGION_VIEW, 20);
      run_region(REGION_DEEP, 8);
      run_region(REGION_WILD, 16);
      run_region(REGION_ZOOM, 24);

      wait_idle();
      $display("Sent %0d pixels over %0d register writes: extremes, wrap-around, zero and",
               pixels_sent, regs_written);
      $display("full limits, then random views of the plane; %0d results checked, %0d bad.",
               results_checked, mismatches);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/mbrot_pkg.sv
rtl/mbrot_queue.sv
rtl/mbrot_front.sv
rtl/mbrot_back.sv
rtl/mandelbrot_escape_time_pixel.sv
rtl/mbrot_checker.sv
dv/mandelbrot_escape_time_pixel_tb.sv
